[src/ffha_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and constants for the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam int HEAP_BYTES_DEF    = 65536;
    localparam int ALIGN_BYTES_DEF   = 8;
    localparam int TABLE_ENTRIES_DEF = 256;
    localparam int HEADER_BYTES_DEF  = 24;
    localparam int SPLIT_MIN         = 24;

    localparam int OFF_W  = 16;
    localparam int SIZE_W = 17;

    typedef enum logic [0:0] {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_ZERO          = 3'd1,
        ST_EXHAUSTED     = 3'd2,
        ST_NOT_ALLOCATED = 3'd3,
        ST_TABLE_FULL    = 3'd4
    } status_t;

    localparam logic [0:0] REG_HEAP_BASE = 1'b0;

    typedef struct packed {
        logic        command;
        logic [15:0] request_size;
        logic [31:0] address;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] granted_address;
        logic [16:0] granted_size;
    } rsp_t;

endpackage
`default_nettype wire

[src/ffha_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffha_ram
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// ----------------------------------------------------------------------------
module ffha_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[src/first_fit_heap_allocator_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_top
// First-fit allocator with split and coalesce over free and used tables.
// ----------------------------------------------------------------------------
// Sequencing: each table entry scanned or shifted takes a read step and then a
//   compare or write step; one table RAM read and write per cycle under a single
//   sequencer. Allocate scans the free table and may remove an entry; free runs a
//   used scan and shift, an insert scan and move, and up to two removals.
// Throughput: one request at a time; in_ready stays low from accept until the
//   result beat leaves.
// Reset: counts, bump offset and heap_base clear; table RAMs need no clear.
module first_fit_heap_allocator_top #(
    parameter int HEAP_BYTES    = ffha_pkg::HEAP_BYTES_DEF,
    parameter int ALIGN_BYTES   = ffha_pkg::ALIGN_BYTES_DEF,
    parameter int TABLE_ENTRIES = ffha_pkg::TABLE_ENTRIES_DEF,
    parameter int HEADER_BYTES  = ffha_pkg::HEADER_BYTES_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire ffha_pkg::req_t in_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output ffha_pkg::rsp_t      out_data,
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [2:0]     paddr,
    input  wire logic [31:0]    pwdata,
    output logic      [31:0]    prdata,
    output logic                pready
);
    import ffha_pkg::*;

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int CW = AW + 1;
    localparam int MIN_REM = (SPLIT_MIN > HEADER_BYTES) ? SPLIT_MIN : HEADER_BYTES;
    localparam logic [SIZE_W:0] HDR  = (SIZE_W+1)'(HEADER_BYTES);
    localparam logic [SIZE_W:0] HEAP = (SIZE_W+1)'(HEAP_BYTES);
    localparam logic [CW-1:0]   FULL = CW'(TABLE_ENTRIES);

    typedef enum logic [11:0] {
        S_IDLE   = 12'b000000000001,
        S_CHECK  = 12'b000000000010,
        S_FRD    = 12'b000000000100, // free scan read issue/compare
        S_FCMP   = 12'b000000001000,
        S_UFIND  = 12'b000000010000,
        S_UCMP   = 12'b000000100000,
        S_USHIFT = 12'b000001000000,
        S_FSHIFT = 12'b000010000000, // remove from free list
        S_ISCAN  = 12'b000100000000,
        S_IMOVE  = 12'b001000000000,
        S_MERGE  = 12'b010000000000,
        S_DONE   = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;
    logic [31:0] base_reg;
    logic [CW-1:0] fcnt_reg, fcnt_next, ucnt_reg, ucnt_next;
    logic [SIZE_W-1:0] bump_reg, bump_next;
    req_t req_reg, req_next;
    rsp_t rsp_reg, rsp_next;
    logic out_valid_reg, out_valid_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] k_reg, k_next;
    logic [SIZE_W-1:0] pad_reg, pad_next;
    logic [OFF_W-1:0] off_reg, off_next;
    logic [SIZE_W-1:0] sz_reg, sz_next;
    logic [2:0] ph_reg, ph_next;       // merge phase / subphase
    logic [0:0] toff_reg, toff_next;

    // RAM ports
    logic f_we, u_we;
    logic [AW-1:0] f_wa, f_ra, u_wa, u_ra;
    logic [OFF_W-1:0] fo_wd, fo_rd, uo_wd, uo_rd;
    logic [SIZE_W-1:0] fs_wd, fs_rd, us_wd, us_rd;

    ffha_ram #(.WIDTH(OFF_W), .DEPTH(TABLE_ENTRIES)) u_fo (.clk(clk), .we(f_we),
        .waddr(f_wa), .wdata(fo_wd), .raddr(f_ra), .rdata(fo_rd));
    ffha_ram #(.WIDTH(SIZE_W), .DEPTH(TABLE_ENTRIES)) u_fs (.clk(clk), .we(f_we),
        .waddr(f_wa), .wdata(fs_wd), .raddr(f_ra), .rdata(fs_rd));
    ffha_ram #(.WIDTH(OFF_W), .DEPTH(TABLE_ENTRIES)) u_uo (.clk(clk), .we(u_we),
        .waddr(u_wa), .wdata(uo_wd), .raddr(u_ra), .rdata(uo_rd));
    ffha_ram #(.WIDTH(SIZE_W), .DEPTH(TABLE_ENTRIES)) u_us (.clk(clk), .we(u_we),
        .waddr(u_wa), .wdata(us_wd), .raddr(u_ra), .rdata(us_rd));

    // shared adder: a + b + header
    logic [SIZE_W:0] add_a, add_b, add_y;
    assign add_y = add_a + add_b + HDR;

    assign pready   = 1'b1;
    assign prdata   = base_reg;
    assign in_ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
        end
        else if (psel && penable && pwrite && paddr[2] == REG_HEAP_BASE)
        begin
            base_reg <= pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fcnt_reg      <= '0;
            ucnt_reg      <= '0;
            bump_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fcnt_reg      <= fcnt_next;
            ucnt_reg      <= ucnt_next;
            bump_reg      <= bump_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        rsp_reg  <= rsp_next;
        idx_reg  <= idx_next;
        k_reg    <= k_next;
        pad_reg  <= pad_next;
        off_reg  <= off_next;
        sz_reg   <= sz_next;
        ph_reg   <= ph_next;
        toff_reg <= toff_next;
    end

    logic [31:0] uaddr;
    assign uaddr = base_reg + 32'(uo_rd) + 32'(HEADER_BYTES);

    always_comb
    begin
        state_next = state_reg;
        fcnt_next = fcnt_reg;
        ucnt_next = ucnt_reg;
        bump_next = bump_reg;
        out_valid_next = out_valid_reg;
        req_next = req_reg;
        rsp_next = rsp_reg;
        idx_next = idx_reg;
        k_next = k_reg;
        pad_next = pad_reg;
        off_next = off_reg;
        sz_next = sz_reg;
        ph_next = ph_reg;
        toff_next = toff_reg;
        f_we = 1'b0; u_we = 1'b0;
        f_wa = idx_reg[AW-1:0]; f_ra = idx_reg[AW-1:0];
        u_wa = idx_reg[AW-1:0]; u_ra = idx_reg[AW-1:0];
        fo_wd = off_reg; fs_wd = sz_reg; uo_wd = off_reg; us_wd = sz_reg;
        add_a = '0; add_b = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    req_next = in_data;
                    pad_next = SIZE_W'(in_data.request_size)
                        + SIZE_W'(ALIGN_BYTES)
                        - SIZE_W'(in_data.request_size % ALIGN_BYTES);
                    idx_next = '0;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                rsp_next = '0;
                add_a = {1'b0, bump_reg};
                add_b = {1'b0, pad_reg};
                idx_next = '0;
                if (req_reg.command == CMD_FREE)
                begin
                    state_next = S_UFIND;
                end
                else if (req_reg.request_size == '0)
                begin
                    rsp_next.status = ST_ZERO;
                    state_next = S_DONE;
                end
                else if (add_y > HEAP)
                begin
                    rsp_next.status = ST_EXHAUSTED;
                    state_next = S_DONE;
                end
                else if (ucnt_reg >= FULL)
                begin
                    rsp_next.status = ST_TABLE_FULL;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_FRD;
                end
            end
            S_FRD:
            begin
                if (idx_reg >= fcnt_reg)
                begin
                    off_next = bump_reg[OFF_W-1:0];
                    sz_next = pad_reg;
                    add_a = {1'b0, bump_reg};
                    add_b = {1'b0, pad_reg};
                    bump_next = add_y[SIZE_W-1:0];
                    ph_next = 3'd0;
                    state_next = S_MERGE;
                end
                else
                begin
                    state_next = S_FCMP;
                end
            end
            S_FCMP:
            begin
                if (fs_rd < pad_reg)
                begin
                    idx_next = idx_reg + 1'b1;
                    state_next = S_FRD;
                end
                else if (fs_rd - pad_reg >= SIZE_W'(MIN_REM))
                begin
                    off_next = fo_rd;
                    sz_next = pad_reg;
                    add_a = {1'b0, fo_rd};
                    add_b = {1'b0, pad_reg};
                    f_we = 1'b1;
                    fo_wd = add_y[OFF_W-1:0];
                    fs_wd = fs_rd - pad_reg - SIZE_W'(HEADER_BYTES);
                    ph_next = 3'd0;
                    state_next = S_MERGE;
                end
                else
                begin
                    off_next = fo_rd;
                    sz_next = fs_rd;
                    ph_next = 3'd1;
                    k_next = idx_reg;
                    toff_next[0] = 1'b0;
                    state_next = S_FSHIFT;
                end
            end
            S_FSHIFT:
            begin
                // alternating steps: read idx+1, then write idx
                if (idx_reg + 1'b1 >= fcnt_reg)
                begin
                    fcnt_next = fcnt_reg - 1'b1;
                    state_next = S_MERGE;
                end
                else if (!toff_reg[0])
                begin
                    f_ra = AW'(idx_reg + 1'b1);
                    toff_next[0] = 1'b1;
                end
                else
                begin
                    f_we = 1'b1;
                    fo_wd = fo_rd;
                    fs_wd = fs_rd;
                    idx_next = idx_reg + 1'b1;
                    toff_next[0] = 1'b0;
                end
            end
            S_MERGE:
            begin
                // allocate completion / free merge, selected by command
                if (req_reg.command == CMD_ALLOC)
                begin
                    u_we = 1'b1;
                    u_wa = ucnt_reg[AW-1:0];
                    ucnt_next = ucnt_reg + 1'b1;
                    rsp_next.status = ST_OK;
                    rsp_next.granted_address = base_reg + 32'(off_reg) + 32'(HEADER_BYTES);
                    rsp_next.granted_size = sz_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    unique case (ph_reg)
                        3'd0:
                        begin
                            // read next block (k+1)
                            f_ra = AW'(k_reg + 1'b1);
                            ph_next = 3'd1;
                        end
                        3'd1:
                        begin
                            // hold the read of k+1 for the merge step
                            f_ra = AW'(k_reg + 1'b1);
                            add_a = {1'b0, off_reg};
                            add_b = {1'b0, sz_reg};
                            if (k_reg + 1'b1 < fcnt_reg && add_y == {1'b0, 1'b0, fo_rd})
                            begin
                                ph_next = 3'd2;
                            end
                            else
                            begin
                                ph_next = 3'd4;
                            end
                        end
                        3'd2:
                        begin
                            // write merged at k, remove k+1
                            add_a = {1'b0, sz_reg};
                            add_b = {1'b0, fs_rd};
                            sz_next = add_y[SIZE_W-1:0];
                            f_we = 1'b1;
                            f_wa = k_reg[AW-1:0];
                            fs_wd = add_y[SIZE_W-1:0];
                            idx_next = k_reg + 1'b1;
                            toff_next[0] = 1'b0;
                            ph_next = 3'd3;
                        end
                        3'd3:
                        begin
                            if (idx_reg + 1'b1 >= fcnt_reg)
                            begin
                                fcnt_next = fcnt_reg - 1'b1;
                                ph_next = 3'd4;
                            end
                            else if (!toff_reg[0])
                            begin
                                f_ra = AW'(idx_reg + 1'b1);
                                toff_next[0] = 1'b1;
                            end
                            else
                            begin
                                f_we = 1'b1;
                                fo_wd = fo_rd;
                                fs_wd = fs_rd;
                                idx_next = idx_reg + 1'b1;
                                toff_next[0] = 1'b0;
                            end
                        end
                        3'd4:
                        begin
                            f_ra = AW'(k_reg - 1'b1);
                            ph_next = 3'd5;
                        end
                        3'd5:
                        begin
                            // hold the read of k-1 for the merge step
                            f_ra = AW'(k_reg - 1'b1);
                            add_a = {1'b0, fo_rd};
                            add_b = {1'b0, fs_rd};
                            if (k_reg != '0 && add_y == {1'b0, 1'b0, off_reg})
                            begin
                                ph_next = 3'd6;
                            end
                            else
                            begin
                                rsp_next = '0;
                                state_next = S_DONE;
                            end
                        end
                        3'd6:
                        begin
                            // write merged at k-1, remove k
                            add_a = {1'b0, fs_rd};
                            add_b = {1'b0, sz_reg};
                            f_we = 1'b1;
                            f_wa = AW'(k_reg - 1'b1);
                            fo_wd = fo_rd;
                            fs_wd = add_y[SIZE_W-1:0];
                            idx_next = k_reg;
                            toff_next[0] = 1'b0;
                            ph_next = 3'd7;
                        end
                        3'd7:
                        begin
                            if (idx_reg + 1'b1 >= fcnt_reg)
                            begin
                                fcnt_next = fcnt_reg - 1'b1;
                                rsp_next = '0;
                                state_next = S_DONE;
                            end
                            else if (!toff_reg[0])
                            begin
                                f_ra = AW'(idx_reg + 1'b1);
                                toff_next[0] = 1'b1;
                            end
                            else
                            begin
                                f_we = 1'b1;
                                fo_wd = fo_rd;
                                fs_wd = fs_rd;
                                idx_next = idx_reg + 1'b1;
                                toff_next[0] = 1'b0;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_UFIND:
            begin
                if (idx_reg >= ucnt_reg)
                begin
                    rsp_next.status = ST_NOT_ALLOCATED;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_UCMP;
                end
            end
            S_UCMP:
            begin
                if (uaddr == req_reg.address)
                begin
                    if (fcnt_reg >= FULL)
                    begin
                        rsp_next.status = ST_TABLE_FULL;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        off_next = uo_rd;
                        sz_next = us_rd;
                        toff_next = '0;
                        state_next = S_USHIFT;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    state_next = S_UFIND;
                end
            end
            S_USHIFT:
            begin
                if (idx_reg + 1'b1 >= ucnt_reg)
                begin
                    ucnt_next = ucnt_reg - 1'b1;
                    idx_next = '0;
                    state_next = S_ISCAN;
                    ph_next = 3'd0;
                end
                else if (!toff_reg[0])
                begin
                    u_ra = AW'(idx_reg + 1'b1);
                    toff_next[0] = 1'b1;
                end
                else
                begin
                    u_we = 1'b1;
                    uo_wd = uo_rd;
                    us_wd = us_rd;
                    idx_next = idx_reg + 1'b1;
                    toff_next[0] = 1'b0;
                end
            end
            S_ISCAN:
            begin
                // find k: first entry with offset >= off
                if (ph_reg == 3'd0)
                begin
                    if (idx_reg >= fcnt_reg)
                    begin
                        k_next = idx_reg;
                        idx_next = fcnt_reg;
                        toff_next[0] = 1'b0;
                        state_next = S_IMOVE;
                    end
                    else
                    begin
                        ph_next = 3'd1;
                    end
                end
                else if (fo_rd < off_reg)
                begin
                    idx_next = idx_reg + 1'b1;
                    ph_next = 3'd0;
                end
                else
                begin
                    k_next = idx_reg;
                    idx_next = fcnt_reg;
                    toff_next[0] = 1'b0;
                    state_next = S_IMOVE;
                end
            end
            S_IMOVE:
            begin
                // shift up from fcnt down to k, then write new entry
                if (idx_reg == k_reg)
                begin
                    f_we = 1'b1;
                    f_wa = k_reg[AW-1:0];
                    fcnt_next = fcnt_reg + 1'b1;
                    ph_next = 3'd0;
                    state_next = S_MERGE;
                end
                else if (!toff_reg[0])
                begin
                    f_ra = AW'(idx_reg - 1'b1);
                    toff_next[0] = 1'b1;
                end
                else
                begin
                    f_we = 1'b1;
                    fo_wd = fo_rd;
                    fs_wd = fs_rd;
                    idx_next = idx_reg - 1'b1;
                    toff_next[0] = 1'b0;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n) ucnt_reg <= FULL)
        else $error("used count overflow");
    assert property (@(posedge clk) disable iff (!rst_n) fcnt_reg <= FULL)
        else $error("free count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && rsp_reg.status != ST_OK) |-> rsp_reg.granted_size == '0)
        else $error("error result carries a size");
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("accepted while busy");
`endif
endmodule
`default_nettype wire
